@@ design/skdo_pkg.sv @@
// Package: shared constants, types and state codes for the stochastic K/D oscillator
`default_nettype none
package skdo_pkg;
   localparam int WINDOW_MAX = 64;
   localparam int AVG_MAX    = 16;
   localparam int WPTR_W     = $clog2(WINDOW_MAX);
   localparam int APTR_W     = $clog2(AVG_MAX);
   localparam int WLEN_W     = 7;
   localparam int ALEN_W     = 5;
   localparam int PRICE_W    = 32;
   localparam int KV_W       = 23;
   localparam int ST_W       = 2;
   localparam int CNT_MAX    = WINDOW_MAX + AVG_MAX;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);
   localparam logic [KV_W-1:0] K_SCALE = KV_W'(6553600);
   // quotient width of num*K_SCALE/den where num <= den
   localparam int Q_W        = KV_W;
   localparam int PROD_W     = PRICE_W + KV_W;
   localparam int SUM_W      = KV_W + APTR_W + 1;
   localparam int ACNT_W     = APTR_W + 1;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_WARM    = 2'd1;
   localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

   localparam logic CSR_WINDOW_LEN = 1'b0;
   localparam logic CSR_AVG_LEN    = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_SCAN, S_SCAN_LAST, S_KCALC, S_KDIV,
      S_AVG, S_AVG_LAST, S_DDIV, S_DONE, S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture input word
      logic write_ring;  // store candle at write pointer
      logic scan_start;
      logic scan_step;
      logic k_setup;     // set up K divisions
      logic div_step;
      logic avg_start;
      logic avg_step;
      logic d_setup;
      logic finish;      // commit smoothing K, advance pointers, form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic avg_last;
      logic div_done;
      logic need_avg;
   } sts_type;
endpackage
`default_nettype wire

@@ design/skdo_if.sv @@
// Interfaces: candle input, result output and register write channels
`default_nettype none
interface skdo_req_if;
   logic                            valid;
   logic                            ready;
   logic [skdo_pkg::PRICE_W-1:0]    low_price;
   logic [skdo_pkg::PRICE_W-1:0]    high_price;
   logic [skdo_pkg::PRICE_W-1:0]    close_price;
   modport source (output valid, low_price, high_price, close_price, input ready);
   modport sink (input valid, low_price, high_price, close_price, output ready);
endinterface

interface skdo_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [skdo_pkg::KV_W-1:0]    k_value;
   logic [skdo_pkg::KV_W-1:0]    d_value;
   logic [skdo_pkg::ST_W-1:0]    status;
   modport source (output valid, k_value, d_value, status, input ready);
   modport sink (input valid, k_value, d_value, status, output ready);
endinterface

interface skdo_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [7:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/skdo_ctrl.sv @@
// Controller: sequences load, window scan, divisions, averaging and result
`default_nettype none
module skdo_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_fire,
   input  wire logic               out_fire,
   input  wire skdo_pkg::sts_type  sts,
   output skdo_pkg::cmd_type       cmd,
   output logic                    in_ready,
   output logic                    out_valid
);
   skdo_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skdo_pkg::S_IDLE:      if (in_fire) state_in = skdo_pkg::S_WRITE;
         skdo_pkg::S_WRITE:     state_in = skdo_pkg::S_SCAN;
         skdo_pkg::S_SCAN:      if (sts.scan_last) state_in = skdo_pkg::S_SCAN_LAST;
         skdo_pkg::S_SCAN_LAST: state_in = skdo_pkg::S_KCALC;
         skdo_pkg::S_KCALC:     state_in = skdo_pkg::S_KDIV;
         skdo_pkg::S_KDIV: begin
            if (sts.div_done) state_in = sts.need_avg ? skdo_pkg::S_AVG : skdo_pkg::S_DONE;
         end
         skdo_pkg::S_AVG:       if (sts.avg_last) state_in = skdo_pkg::S_AVG_LAST;
         skdo_pkg::S_AVG_LAST:  state_in = skdo_pkg::S_DDIV;
         skdo_pkg::S_DDIV:      if (sts.div_done) state_in = skdo_pkg::S_DONE;
         skdo_pkg::S_DONE:      state_in = skdo_pkg::S_OUT;
         skdo_pkg::S_OUT:       if (out_fire) state_in = skdo_pkg::S_IDLE;
         default:               state_in = skdo_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         skdo_pkg::S_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_fire;
         end
         skdo_pkg::S_WRITE: begin
            cmd.write_ring = 1'b1;
            cmd.scan_start = 1'b1;
         end
         skdo_pkg::S_SCAN:      cmd.scan_step = 1'b1;
         skdo_pkg::S_SCAN_LAST: cmd.scan_step = 1'b1;
         skdo_pkg::S_KCALC:     cmd.k_setup = 1'b1;
         skdo_pkg::S_KDIV: begin
            cmd.div_step = 1'b1;
            cmd.avg_start = sts.div_done;
         end
         skdo_pkg::S_AVG:       cmd.avg_step = 1'b1;
         skdo_pkg::S_AVG_LAST: begin
            cmd.avg_step = 1'b1;
            cmd.d_setup = 1'b1;
         end
         skdo_pkg::S_DDIV:      cmd.div_step = 1'b1;
         skdo_pkg::S_DONE:      cmd.finish = 1'b1;
         skdo_pkg::S_OUT:       out_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= skdo_pkg::S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ design/skdo_dp.sv @@
// Datapath: candle rings, window scan, shared restoring divider and K averaging
`default_nettype none
module skdo_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire skdo_pkg::cmd_type             cmd,
   output skdo_pkg::sts_type                  sts,
   input  wire logic [skdo_pkg::PRICE_W-1:0]  low_price,
   input  wire logic [skdo_pkg::PRICE_W-1:0]  high_price,
   input  wire logic [skdo_pkg::PRICE_W-1:0]  close_price,
   input  wire logic                          csr_we,
   input  wire logic [0:0]                    csr_idx,
   input  wire logic [7:0]                    csr_data,
   output logic [skdo_pkg::KV_W-1:0]          k_value,
   output logic [skdo_pkg::KV_W-1:0]          d_value,
   output logic [skdo_pkg::ST_W-1:0]          status
);
   localparam int WP = skdo_pkg::WPTR_W;
   localparam int AP = skdo_pkg::APTR_W;
   localparam int PW = skdo_pkg::PRICE_W;
   localparam int KW = skdo_pkg::KV_W;
   localparam int DIVW = skdo_pkg::PROD_W;
   localparam logic [KW-1:0] K_SCALE_W = skdo_pkg::K_SCALE;

   // configuration
   logic [skdo_pkg::WLEN_W-1:0] wlen_ff;
   logic [skdo_pkg::ALEN_W-1:0] alen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= skdo_pkg::WLEN_W'(9);
         alen_ff <= skdo_pkg::ALEN_W'(3);
      end else if (csr_we) begin
         if (csr_idx == skdo_pkg::CSR_WINDOW_LEN) wlen_ff <= csr_data[skdo_pkg::WLEN_W-1:0];
         else                                     alen_ff <= csr_data[skdo_pkg::ALEN_W-1:0];
      end
   end
   // clamped lengths, stored as length (1..MAX)
   logic [WP:0] w_len;
   logic [AP:0] a_len;
   always_comb begin
      if (wlen_ff == '0) w_len = (WP+1)'(1);
      else if (32'(wlen_ff) > skdo_pkg::WINDOW_MAX) w_len = (WP+1)'(skdo_pkg::WINDOW_MAX);
      else w_len = (WP+1)'(wlen_ff);
      if (alen_ff == '0) a_len = (AP+1)'(1);
      else if (32'(alen_ff) > skdo_pkg::AVG_MAX) a_len = (AP+1)'(skdo_pkg::AVG_MAX);
      else a_len = (AP+1)'(alen_ff);
   end

   // input word
   logic [PW-1:0] lo_ff, hi_ff, cl_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff <= low_price;
         hi_ff <= high_price;
         cl_ff <= close_price;
      end
   end

   // pointers and counters
   logic [WP-1:0] wptr_ff;
   logic [AP-1:0] aptr_ff;
   logic [skdo_pkg::CNT_W-1:0] cnt_ff;
   logic [skdo_pkg::WINDOW_MAX-1:0] ok_ff;
   logic [skdo_pkg::AVG_MAX-1:0]    skv_ff;

   // warm-up: cnt < w-1, need avg: cnt >= w+a-2
   logic warm, need_avg;
   assign warm     = (32'(cnt_ff) + 32'd1) < 32'(w_len);
   assign need_avg = (32'(cnt_ff) + 32'd2) >= (32'(w_len) + 32'(a_len));

   // price ring (one memory holding high and low)
   logic [2*PW-1:0] pmem [skdo_pkg::WINDOW_MAX];
   logic [2*PW-1:0] prd_ff;
   logic [WP-1:0]   raddr_ff;
   logic            rok_ff;
   logic [WP:0]     scnt_ff;
   logic            rvalid_ff;
   always_ff @(posedge clock) begin
      if (cmd.write_ring) pmem[wptr_ff] <= {hi_ff, lo_ff};
      prd_ff <= pmem[raddr_ff];
   end

   // scan: address issue, then accumulate from the registered read data
   logic [PW-1:0] vmin_ff, vmax_ff;
   logic          anybad_ff, anyok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         raddr_ff  <= wptr_ff;
         scnt_ff   <= (WP+1)'(1);
         rvalid_ff <= 1'b0;
         vmin_ff   <= '1;
         vmax_ff   <= '0;
         anybad_ff <= 1'b0;
         anyok_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         rvalid_ff <= (scnt_ff <= w_len);
         rok_ff    <= ok_ff[raddr_ff];
         raddr_ff  <= raddr_ff - WP'(1);
         scnt_ff   <= scnt_ff + (WP+1)'(1);
         if (rvalid_ff) begin
            if (rok_ff) begin
               anyok_ff <= 1'b1;
               if (prd_ff[PW-1:0] < vmin_ff) vmin_ff <= prd_ff[PW-1:0];
               if (prd_ff[2*PW-1:PW] > vmax_ff) vmax_ff <= prd_ff[2*PW-1:PW];
            end else begin
               anybad_ff <= 1'b1;
            end
         end
      end
   end
   assign sts.scan_last = (scnt_ff > w_len);

   // K setup: numerator/denominator, validity
   logic [PW-1:0] num_c, den_c;
   logic          kok_c, keq_c;
   always_comb begin
      keq_c = (vmin_ff == vmax_ff);
      if (vmax_ff >= vmin_ff) begin
         den_c = vmax_ff - vmin_ff;
         num_c = cl_ff - vmin_ff;
         kok_c = (cl_ff >= vmin_ff) && (cl_ff <= vmax_ff);
      end else begin
         den_c = vmin_ff - vmax_ff;
         num_c = vmin_ff - cl_ff;
         kok_c = (cl_ff <= vmin_ff) && (cl_ff >= vmax_ff);
      end
      if (cl_ff == '0) kok_c = 1'b0;
      else if (keq_c) kok_c = 1'b1;
   end

   // shared restoring divider: one quotient bit a cycle
   logic [DIVW-1:0] rem_ff, dvs_ff;
   logic [DIVW-1:0] dvd_ff;
   logic [KW-1:0]   quo_ff;
   logic [5:0]      dcnt_ff;
   logic            kzero_ff, kok_ff;
   logic [skdo_pkg::PROD_W-1:0] prod_ff;
   logic [DIVW:0]   trial;
   logic            cmd_is_d_ff;
   assign trial = {rem_ff, dvd_ff[DIVW-1]} - {1'b0, dvs_ff};
   assign sts.div_done = (dcnt_ff == '0);

   // averaging
   logic [skdo_pkg::KV_W-1:0] skmem [skdo_pkg::AVG_MAX];
   logic [AP-1:0]   aaddr_ff;
   logic [AP:0]     acnt_i_ff;
   logic            avalid_ff, avok_ff;
   logic [KW-1:0]   ard_ff;
   logic [skdo_pkg::SUM_W-1:0]  sum_ff;
   logic [skdo_pkg::ACNT_W-1:0] nsum_ff;
   logic [KW-1:0]   kres_ff;
   logic            sk_ok;
   logic [KW-1:0]   sk_val;
   logic            sk_ok_pre;
   logic [KW-1:0]   sk_val_pre;
   logic [skdo_pkg::AVG_MAX-1:0] skv_now;
   assign sk_ok  = warm ? 1'b1 : (anyok_ff && kok_ff);
   assign sk_val = (warm || !sk_ok) ? '0 : kres_ff;
   assign sts.need_avg = !warm && !anybad_ff && (cl_ff != '0) && kok_ff && need_avg;
   assign sts.avg_last = (acnt_i_ff >= a_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.k_setup) begin
         kok_ff   <= kok_c;
         kzero_ff <= keq_c;
         prod_ff  <= DIVW'(num_c) * DIVW'(K_SCALE_W);
         dcnt_ff  <= 6'(KW + 1);
      end else if (cmd.d_setup) begin
         dcnt_ff  <= 6'(KW + 1);
      end else if (cmd.div_step && dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 6'd1;
      end
   end

   // divider shift: first step loads, then KW quotient bits (quotient < 2^KW)
   always_ff @(posedge clock) begin
      if (cmd.div_step && dcnt_ff == 6'(KW + 1)) begin
         if (cmd_is_d_ff) begin
            dvd_ff <= DIVW'(sum_ff) << (DIVW - KW);
            dvs_ff <= DIVW'(nsum_ff);
         end else begin
            dvd_ff <= prod_ff << (DIVW - KW);
            dvs_ff <= DIVW'(den_c);
         end
         // dividend top bits beyond KW are zero because quotient fits KW bits
         rem_ff <= cmd_is_d_ff ? (DIVW'(sum_ff) >> KW) : (prod_ff >> KW);
         quo_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != '0) begin
         if (!trial[DIVW]) begin
            rem_ff <= trial[DIVW-1:0];
            quo_ff <= {quo_ff[KW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DIVW-2:0], dvd_ff[DIVW-1]};
            quo_ff <= {quo_ff[KW-2:0], 1'b0};
         end
         dvd_ff <= dvd_ff << 1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cmd_is_d_ff <= 1'b0;
      else if (cmd.k_setup) cmd_is_d_ff <= 1'b0;
      else if (cmd.d_setup) cmd_is_d_ff <= 1'b1;
   end

   // K result latched after its division
   always_ff @(posedge clock) begin
      if (cmd.avg_start || (cmd.finish && !cmd_is_d_ff)) begin
         if (!cmd_is_d_ff) kres_ff <= kzero_ff ? '0 : quo_ff;
      end
   end

   // the current item's smoothing K sits in the ring before averaging
   always_ff @(posedge clock) begin
      if (cmd.avg_start) skmem[aptr_ff] <= sk_val_pre;
      else if (cmd.finish && !sts.need_avg) skmem[aptr_ff] <= sk_val;
      ard_ff <= skmem[aaddr_ff];
   end
   assign sk_ok_pre  = warm ? 1'b1 : (anyok_ff && kok_ff);
   assign sk_val_pre = (warm || !sk_ok_pre) ? '0 : (kzero_ff ? '0 : quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.avg_start) begin
         aaddr_ff  <= aptr_ff;
         acnt_i_ff <= '0;
         avalid_ff <= 1'b0;
         sum_ff    <= '0;
         nsum_ff   <= '0;
      end else if (cmd.avg_step) begin
         aaddr_ff  <= aaddr_ff - AP'(1);
         acnt_i_ff <= acnt_i_ff + (AP+1)'(1);
         avalid_ff <= (acnt_i_ff < a_len);
         avok_ff   <= skv_now[aaddr_ff];
         if (avalid_ff && avok_ff) begin
            sum_ff  <= sum_ff + skdo_pkg::SUM_W'(ard_ff);
            nsum_ff <= nsum_ff + skdo_pkg::ACNT_W'(1);
         end
      end
   end
   // valid bits including this item's entry once written
   assign skv_now = skv_ff;

   // commit pointers, valid bits and result
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         aptr_ff <= '0;
         cnt_ff  <= '0;
         ok_ff   <= '0;
         skv_ff  <= '0;
      end else begin
         if (cmd.write_ring) ok_ff[wptr_ff] <= (lo_ff != '0) && (hi_ff != '0);
         if (cmd.avg_start) skv_ff[aptr_ff] <= sk_ok_pre;
         if (cmd.finish) begin
            if (!sts.need_avg) begin
               skv_ff[aptr_ff] <= sk_ok;
            end
            wptr_ff <= wptr_ff + WP'(1);
            aptr_ff <= aptr_ff + AP'(1);
            if (32'(cnt_ff) < skdo_pkg::CNT_MAX) cnt_ff <= cnt_ff + skdo_pkg::CNT_W'(1);
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (warm) begin
            status <= skdo_pkg::ST_WARM; k_value <= '0; d_value <= '0;
         end else if (anybad_ff || cl_ff == '0) begin
            status <= skdo_pkg::ST_INVALID; k_value <= '0; d_value <= '0;
         end else if (!kok_ff) begin
            status <= skdo_pkg::ST_RANGE; k_value <= '0; d_value <= '0;
         end else begin
            status  <= skdo_pkg::ST_OK;
            k_value <= kres_ff;
            if (cmd_is_d_ff && nsum_ff != '0) d_value <= quo_ff;
            else d_value <= kres_ff;
         end
      end
   end
endmodule
`default_nettype wire

@@ design/stochastic_kd_oscillator_unit.sv @@
// Top level: stochastic K/D oscillator, controller plus datapath
// One candle is processed at a time; the window scan and the bit-serial divider set its pace.
// Result is held in an output register until taken; a new word is taken after that.
// Reset (synchronous, active high) clears pointers, counters and valid bits, and sets the length registers to defaults.
`default_nettype none
module stochastic_kd_oscillator_unit (
   input wire logic  clock,
   input wire logic  reset,
   skdo_req_if.sink  req,
   skdo_rsp_if.source rsp,
   skdo_csr_if.sink  csr
);
   skdo_pkg::cmd_type cmd;
   skdo_pkg::sts_type sts;
   logic in_fire, out_fire;
   assign in_fire  = req.valid && req.ready;
   assign out_fire = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;

   skdo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .out_fire(out_fire),
      .sts(sts), .cmd(cmd), .in_ready(req.ready), .out_valid(rsp.valid)
   );

   skdo_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .low_price(req.low_price), .high_price(req.high_price),
      .close_price(req.close_price),
      .csr_we(csr.valid), .csr_idx(csr.index), .csr_data(csr.data),
      .k_value(rsp.k_value), .d_value(rsp.d_value), .status(rsp.status)
   );

`ifndef SYNTHESIS
   // no input word taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken while result pending");
   // a taken result is dropped next cycle
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> !rsp.valid) else $error("result repeated");
   // an accepted word does not yield a result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> !rsp.valid) else $error("result too early");
`endif
endmodule
`default_nettype wire

@@ tb/tb_stochastic_kd_oscillator_unit.sv @@
// Testbench: random and directed candles checked against a behavioral K/D oscillator model
`default_nettype none
module tb_stochastic_kd_oscillator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [skdo_pkg::PRICE_W-1:0] lo;
      logic [skdo_pkg::PRICE_W-1:0] hi;
      logic [skdo_pkg::PRICE_W-1:0] cl;
   } candle_type;

   typedef struct packed {
      logic [skdo_pkg::KV_W-1:0] k;
      logic [skdo_pkg::KV_W-1:0] d;
      logic [skdo_pkg::ST_W-1:0] st;
   } osc_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skdo_req_if req ();
   skdo_rsp_if rsp ();
   skdo_csr_if csr ();

   stochastic_kd_oscillator_unit u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic [skdo_pkg::PRICE_W-1:0] m_low [skdo_pkg::WINDOW_MAX];
   logic [skdo_pkg::PRICE_W-1:0] m_high [skdo_pkg::WINDOW_MAX];
   logic                         m_ok [skdo_pkg::WINDOW_MAX];
   logic [skdo_pkg::KV_W-1:0]    m_sk [skdo_pkg::AVG_MAX];
   logic                         m_skv [skdo_pkg::AVG_MAX];
   int unsigned        m_cnt, m_wptr, m_aptr, m_wlen, m_alen;

   candle_type  pending_words[$];
   osc_out_type expected_results[$];
   int       errors = 0;
   int       send_idle = 6, recv_idle = 51;
   bit       recv_hold = 0;
   int       cur_phase = -1;

   // append one candle word to the send queue
   function automatic void add_word(input candle_type c);
      pending_words.insert(pending_words.size(), c);
   endfunction

   // K over one window; returns 0 when out of range or close invalid
   function automatic bit k_of(input longint cl, input longint vmin, input longint vmax,
                               output logic [skdo_pkg::KV_W-1:0] k);
      longint num, den;
      k = '0;
      if (cl == 0) return 0;
      if (vmin == vmax) return 1;
      num = cl - vmin;
      den = vmax - vmin;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num < 0 || num > den) return 0;
      k = skdo_pkg::KV_W'((num * 64'd6553600) / den);
      return 1;
   endfunction

   function automatic osc_out_type osc_predict(input candle_type c);
      osc_out_type r;
      int unsigned w, a, p, nvalid, cnt;
      longint vmin, vmax;
      bit bad, sk_ok, kok;
      logic [skdo_pkg::KV_W-1:0] sk, k;
      longint sum;
      w = (m_wlen < 1) ? 1 : (m_wlen > skdo_pkg::WINDOW_MAX ? skdo_pkg::WINDOW_MAX : m_wlen);
      a = (m_alen < 1) ? 1 : (m_alen > skdo_pkg::AVG_MAX ? skdo_pkg::AVG_MAX : m_alen);
      m_low[m_wptr] = c.lo;
      m_high[m_wptr] = c.hi;
      m_ok[m_wptr] = (c.lo != 0) && (c.hi != 0);
      vmin = 64'hFFFFFFFF; vmax = 0; nvalid = 0; bad = 0; sk = '0;
      for (int i = 0; i < w; i++) begin
         p = (m_wptr + skdo_pkg::WINDOW_MAX - i) % skdo_pkg::WINDOW_MAX;
         if (m_ok[p]) begin
            if (m_low[p] < vmin) vmin = m_low[p];
            if (m_high[p] > vmax) vmax = m_high[p];
            nvalid++;
         end else bad = 1;
      end
      if (m_cnt < w - 1) begin
         sk_ok = 1;
      end else if (nvalid == 0) begin
         sk_ok = 0;
      end else begin
         sk_ok = k_of(c.cl, vmin, vmax, sk);
      end
      m_sk[m_aptr] = sk_ok ? sk : '0;
      m_skv[m_aptr] = sk_ok;
      r = '0;
      if (m_cnt < w - 1) begin
         r.st = skdo_pkg::ST_WARM;
      end else if (bad || c.cl == 0) begin
         r.st = skdo_pkg::ST_INVALID;
      end else begin
         kok = k_of(c.cl, vmin, vmax, k);
         if (!kok) begin
            r.st = skdo_pkg::ST_RANGE;
         end else begin
            r.st = skdo_pkg::ST_OK;
            r.k = k;
            r.d = k;
            if (m_cnt >= w + a - 2) begin
               sum = 0; cnt = 0;
               for (int i = 0; i < a; i++) begin
                  p = (m_aptr + skdo_pkg::AVG_MAX - i) % skdo_pkg::AVG_MAX;
                  if (m_skv[p]) begin
                     sum += m_sk[p];
                     cnt++;
                  end
               end
               if (cnt != 0) r.d = skdo_pkg::KV_W'(sum / cnt);
            end
         end
      end
      m_wptr = (m_wptr + 1) % skdo_pkg::WINDOW_MAX;
      m_aptr = (m_aptr + 1) % skdo_pkg::AVG_MAX;
      if (m_cnt < skdo_pkg::CNT_MAX) m_cnt++;
      return r;
   endfunction

   // driver: candle words from the queue, head stays until taken
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) void'(pending_words.pop_front());
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
            candle_type c;
            c = pending_words[0];
            req.valid <= 1'b1;
            req.low_price <= c.lo;
            req.high_price <= c.hi;
            req.close_price <= c.cl;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // predict on acceptance, so config changes line up with the word stream
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         candle_type c;
         c.lo = req.low_price;
         c.hi = req.high_price;
         c.cl = req.close_price;
         expected_results.insert(expected_results.size(), osc_predict(c));
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word k=%0d d=%0d st=%0d",
                      rsp.k_value, rsp.d_value, rsp.status);
               errors++;
            end else begin
               osc_out_type e;
               e = expected_results.pop_front();
               if (rsp.k_value !== e.k) begin
                  $error("k_value expected %0d actual %0d", e.k, rsp.k_value);
                  errors++;
               end
               if (rsp.d_value !== e.d) begin
                  $error("d_value expected %0d actual %0d", e.d, rsp.d_value);
                  errors++;
               end
               if (rsp.status !== e.st) begin
                  $error("status expected %0d actual %0d", e.st, rsp.status);
                  errors++;
               end
            end
         end
         rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
      end
   end

   // long receiver hold in phase 2 while the sender keeps offering
   initial begin
      wait (cur_phase == 2);
      recv_hold = 1;
      repeat (3000) @(posedge clock);
      recv_hold = 0;
   end

   task automatic csr_write(input logic idx, input logic [7:0] v);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      if (idx == skdo_pkg::CSR_WINDOW_LEN) m_wlen = v[skdo_pkg::WLEN_W-1:0];
      else m_alen = v[skdo_pkg::ALEN_W-1:0];
      csr.valid <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_words.size() == 0 && !req.valid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_price(input logic [31:0] base, input int spread);
      case ($urandom_range(9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return base + $urandom_range(spread);
      endcase
   endfunction

   task automatic push_random(input int n, input int spread);
      candle_type c;
      logic [31:0] base, lo, hi;
      for (int i = 0; i < n; i++) begin
         base = ($urandom_range(3) == 0) ? $urandom() : 32'd1000 + $urandom_range(5000);
         if ($urandom_range(19) == 0) begin
            c.lo = rnd_price(base, spread);
            c.hi = rnd_price(base, spread);
            c.cl = rnd_price(base, spread);
         end else begin
            lo = base + $urandom_range(spread);
            hi = lo + $urandom_range(spread);
            if (lo == 0) lo = 1;
            if (hi == 0) hi = 32'hFFFF_FFFF;
            c.lo = lo;
            c.hi = hi;
            c.cl = lo + $urandom_range(hi - lo > 100000 ? 100000 : hi - lo);
            if ($urandom_range(15) == 0) c.cl = hi + 1;
         end
         add_word(c);
      end
   endtask

   initial begin
      int phase_cfg [6][2] = '{'{9, 3}, '{1, 1}, '{64, 16}, '{0, 0}, '{127, 31}, '{5, 8}};
      csr.valid = 1'b0;
      csr.index = skdo_pkg::CSR_WINDOW_LEN;
      csr.data = '0;
      m_wlen = 9; m_alen = 3;
      m_cnt = 0; m_wptr = 0; m_aptr = 0;
      for (int i = 0; i < skdo_pkg::WINDOW_MAX; i++) m_ok[i] = 0;
      for (int i = 0; i < skdo_pkg::AVG_MAX; i++) m_skv[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: warm-up, extremes, flat window, inverted candle, invalid prices
      add_word('{32'd100, 32'd200, 32'd150});
      add_word('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      add_word('{32'd1, 32'd1, 32'd1});
      add_word('{32'd300, 32'd100, 32'd200});
      add_word('{32'd0, 32'd100, 32'd50});
      add_word('{32'd100, 32'd0, 32'd50});
      add_word('{32'd100, 32'd200, 32'd0});
      for (int i = 0; i < 10; i++) add_word('{32'd100, 32'd200, 32'd100 + i*10});
      add_word('{32'd100, 32'd200, 32'd250});
      add_word('{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      add_word('{32'd1, 32'hFFFF_FFFF, 32'd1});
      add_word('{32'd1, 32'hFFFF_FFFF, 32'hAAAA_5555});
      add_word('{32'd5, 32'd5, 32'd5});
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 12; ph++) begin
         cur_phase = ph;
         if (ph == 4) begin send_idle = 51; recv_idle = 6; end
         if (ph == 8) begin send_idle = 0; recv_idle = 0; end
         csr_write(skdo_pkg::CSR_WINDOW_LEN, 8'(phase_cfg[ph % 6][0]));
         csr_write(skdo_pkg::CSR_AVG_LEN, 8'(phase_cfg[ph % 6][1]));
         if (ph == 2) begin
            push_random(160, 500);
         end else begin
            push_random(160, (ph % 2) ? 50 : 100000);
         end
         drain();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
